// ===== hdl/rate_limited_heading_tracker_unit_assert.svh =====
// Assertion macros for the heading tracker checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RATE_LIMITED_HEADING_TRACKER_UNIT_ASSERT_SVH
`define RATE_LIMITED_HEADING_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RLHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked on a plain property expression.
`define RLHT_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== hdl/rlht_pkg.sv =====
// Package for the heading tracker: fixed-point widths, angle constants,
// the atan table and the word handed from cell to cell. No dependencies.
`timescale 1ns / 1ps

package rlht_pkg;

    localparam int X_W = 48;
    localparam int Z_W = 27;
    localparam int ANG_W = 18;
    localparam int PRE_SHIFT = 24;
    localparam int ROUND_SHIFT = 9;
    localparam int MAX_STEPS = 24;
    localparam int ATAN_W = 23;
    localparam int RATE_W = 20;
    localparam int FT_W = 16;
    localparam int YAW_W = 16;
    localparam int LIMIT_W = RATE_W + FT_W;
    localparam int MAG_W = ANG_W - 1;

    localparam logic signed [ANG_W-1:0] HALF_TURN = 18'sd23040;
    localparam logic signed [ANG_W-1:0] FULL_TURN = 18'sd46080;
    localparam logic signed [ANG_W-1:0] THREE_HALF_TURN = 18'sd69120;
    localparam logic signed [ANG_W-1:0] TWO_TURNS = 18'sd92160;

    localparam logic signed [Z_W-1:0] Z_HALF_TURN = 27'sd11796480;
    localparam logic signed [Z_W-1:0] Z_ROUND = 27'sd256;

    localparam logic [RATE_W-1:0] YAW_RATE_RESET = 20'd23040;
    localparam logic YAW_RATE_IDX = 1'b0;

    // atan(2^-i) in 2^-16 degree
    localparam logic [ATAN_W-1:0] ATAN_TABLE [MAX_STEPS] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379, 23'd117304, 23'd58666, 23'd29335,
        23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115,
        23'd57, 23'd29, 23'd14, 23'd7,
        23'd4, 23'd2, 23'd1, 23'd0
    };

    typedef struct packed {
        logic signed [X_W-1:0]   x;
        logic signed [X_W-1:0]   y;
        logic signed [Z_W-1:0]   z;
        logic signed [YAW_W-1:0] cur;
        logic [FT_W-1:0]         ft;
        logic                    aimed;
    } cell_word_t;

endpackage

// ===== hdl/rate_limited_heading_tracker_unit.sv =====
// Throughput: one word per cycle; busy stays low, the CORDIC is a row of
// CORDIC_STEPS registered cells between an entry stage and four back-end stages.
// Reset: rst_n clears all valid flags and sets yaw_rate to 23040; result words in
// flight are lost, none kept across reset. The receiver cannot stall the result port.
`timescale 1ns / 1ps

module rate_limited_heading_tracker_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [19:0] actor_x,
    input  logic signed [19:0] actor_y,
    input  logic signed [19:0] target_x,
    input  logic signed [19:0] target_y,
    input  logic               target_valid,
    input  logic signed [15:0] current_yaw,
    input  logic [15:0]        frame_time,
    output logic               done,
    output logic signed [15:0] new_yaw,
    output logic               aimed
);

    logic [rlht_pkg::RATE_W-1:0] yaw_rate_reg;
    logic                        cfg_write;
    logic                        accept;
    logic                        chain_valid [CORDIC_STEPS+1];
    rlht_pkg::cell_word_t        chain_word  [CORDIC_STEPS+1];

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == rlht_pkg::YAW_RATE_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_rate_reg <= rlht_pkg::YAW_RATE_RESET;
        end
        else if (cfg_write)
        begin
            yaw_rate_reg <= pwdata[rlht_pkg::RATE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == rlht_pkg::YAW_RATE_IDX)
                    ? {{(32 - rlht_pkg::RATE_W){1'b0}}, yaw_rate_reg} : '0;

    rlht_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .actor_x      (actor_x),
        .actor_y      (actor_y),
        .target_x     (target_x),
        .target_y     (target_y),
        .target_valid (target_valid),
        .current_yaw  (current_yaw),
        .frame_time   (frame_time),
        .out_valid    (chain_valid[0]),
        .out_word     (chain_word[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        rlht_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    rlht_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[CORDIC_STEPS]),
        .in_word  (chain_word[CORDIC_STEPS]),
        .yaw_rate (yaw_rate_reg),
        .done     (done),
        .new_yaw  (new_yaw),
        .aimed    (aimed)
    );

endmodule

// ===== hdl/rlht_cell.sv =====
// One vectoring CORDIC cell: one micro-rotation per word, registered.
// Depends on rlht_pkg.
`timescale 1ns / 1ps

module rlht_cell #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rlht_pkg::cell_word_t in_word,
    output logic                out_valid,
    output rlht_pkg::cell_word_t out_word
);

    logic signed [rlht_pkg::X_W-1:0] x_in;
    logic signed [rlht_pkg::X_W-1:0] y_in;
    logic signed [rlht_pkg::X_W-1:0] xs;
    logic signed [rlht_pkg::X_W-1:0] ys;
    logic signed [rlht_pkg::Z_W-1:0] atan_s;
    rlht_pkg::cell_word_t            word_next;
    rlht_pkg::cell_word_t            word_reg;
    logic                            valid_reg;

    always_comb
    begin
        x_in = in_word.x;
        y_in = in_word.y;
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        atan_s = {{(rlht_pkg::Z_W - rlht_pkg::ATAN_W){1'b0}}, rlht_pkg::ATAN_TABLE[STEP]};
        word_next = in_word;
        if (y_in > 0)
        begin
            word_next.x = x_in + ys;
            word_next.y = y_in - xs;
            word_next.z = in_word.z + atan_s;
        end
        else if (y_in < 0)
        begin
            word_next.x = x_in - ys;
            word_next.y = y_in + xs;
            word_next.z = in_word.z - atan_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hdl/rlht_prep.sv =====
// Entry stage: offsets, aim check and half-plane pre-rotation, registered.
// Depends on rlht_pkg.
`timescale 1ns / 1ps

module rlht_prep (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic signed [19:0]         actor_x,
    input  logic signed [19:0]         actor_y,
    input  logic signed [19:0]         target_x,
    input  logic signed [19:0]         target_y,
    input  logic                       target_valid,
    input  logic signed [rlht_pkg::YAW_W-1:0] current_yaw,
    input  logic [rlht_pkg::FT_W-1:0]  frame_time,
    output logic                       out_valid,
    output rlht_pkg::cell_word_t       out_word
);

    localparam int D_W = 21;

    logic signed [D_W-1:0]           dx;
    logic signed [D_W-1:0]           dy;
    logic signed [rlht_pkg::X_W-1:0] x0;
    logic signed [rlht_pkg::X_W-1:0] y0;
    rlht_pkg::cell_word_t            word_next;
    rlht_pkg::cell_word_t            word_reg;
    logic                            valid_reg;

    always_comb
    begin
        dx = {target_x[19], target_x} - {actor_x[19], actor_x};
        dy = {target_y[19], target_y} - {actor_y[19], actor_y};
        x0 = {{(rlht_pkg::X_W - D_W - rlht_pkg::PRE_SHIFT){dx[D_W-1]}}, dx,
              {rlht_pkg::PRE_SHIFT{1'b0}}};
        y0 = {{(rlht_pkg::X_W - D_W - rlht_pkg::PRE_SHIFT){dy[D_W-1]}}, dy,
              {rlht_pkg::PRE_SHIFT{1'b0}}};
        word_next.cur   = current_yaw;
        word_next.ft    = frame_time;
        word_next.aimed = target_valid && ((dx != '0) || (dy != '0));
        if (dx[D_W-1])
        begin
            // rotate into the right half-plane
            word_next.x = -x0;
            word_next.y = -y0;
            word_next.z = dy[D_W-1] ? -rlht_pkg::Z_HALF_TURN : rlht_pkg::Z_HALF_TURN;
        end
        else
        begin
            word_next.x = x0;
            word_next.y = y0;
            word_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hdl/rlht_post.sv =====
// Back end: round and wrap the bearing, fold the difference, apply the
// turn limit and wrap the new heading, zeroed when not aimed, over four registered stages.
// Depends on rlht_pkg.
`timescale 1ns / 1ps

module rlht_post (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  rlht_pkg::cell_word_t              in_word,
    input  logic [rlht_pkg::RATE_W-1:0]       yaw_rate,
    output logic                              done,
    output logic signed [rlht_pkg::YAW_W-1:0] new_yaw,
    output logic                              aimed
);

    localparam int A = rlht_pkg::ANG_W;

    // stage 1
    logic signed [rlht_pkg::Z_W-1:0]   z_round;
    logic signed [A-1:0]               want_raw;
    logic signed [A-1:0]               want_next;
    logic signed [A-1:0]               want1_reg;
    logic [rlht_pkg::LIMIT_W-1:0]      limit_next;
    logic [rlht_pkg::LIMIT_W-1:0]      limit1_reg;
    logic signed [A-1:0]               cur1_reg;
    logic                              aimed1_reg;
    logic                              v1_reg;

    // stage 2
    logic signed [A-1:0]               delta_raw;
    logic signed [A-1:0]               delta_next;
    logic [A-1:0]                      mag_abs;
    logic [rlht_pkg::MAG_W-1:0]        mag2_reg;
    logic                              pos2_reg;
    logic signed [A-1:0]               want2_reg;
    logic signed [A-1:0]               cur2_reg;
    logic [rlht_pkg::LIMIT_W-1:0]      limit2_reg;
    logic                              aimed2_reg;
    logic                              v2_reg;

    // stage 3
    logic                              fits;
    logic [rlht_pkg::MAG_W-1:0]        step;
    logic signed [A-1:0]               res_next;
    logic signed [A-1:0]               res3_reg;
    logic                              aimed3_reg;
    logic                              v3_reg;

    // stage 4
    logic signed [A-1:0]               wrap_next;
    logic signed [rlht_pkg::YAW_W-1:0] yaw_reg;
    logic                              aimed_reg;
    logic                              done_reg;

    always_comb
    begin
        z_round = in_word.z + rlht_pkg::Z_ROUND;
        want_raw = z_round[rlht_pkg::Z_W-1:rlht_pkg::ROUND_SHIFT];
        if (want_raw > rlht_pkg::HALF_TURN)
        begin
            want_next = want_raw - rlht_pkg::FULL_TURN;
        end
        else if (want_raw <= -rlht_pkg::HALF_TURN)
        begin
            want_next = want_raw + rlht_pkg::FULL_TURN;
        end
        else
        begin
            want_next = want_raw;
        end
        limit_next = yaw_rate * in_word.ft;
    end

    always_comb
    begin
        delta_raw = want1_reg - cur1_reg;
        if (delta_raw > rlht_pkg::HALF_TURN)
        begin
            delta_next = delta_raw - rlht_pkg::FULL_TURN;
        end
        else if (delta_raw < -rlht_pkg::HALF_TURN)
        begin
            delta_next = delta_raw + rlht_pkg::FULL_TURN;
        end
        else
        begin
            delta_next = delta_raw;
        end
        mag_abs = delta_next[A-1] ? A'(-delta_next) : A'(delta_next);
    end

    always_comb
    begin
        fits = limit2_reg >= {3'b000, mag2_reg, 16'h0000};
        step = limit2_reg[32:16];
        if (fits)
        begin
            res_next = want2_reg;
        end
        else if (pos2_reg)
        begin
            res_next = cur2_reg + {1'b0, step};
        end
        else
        begin
            res_next = cur2_reg - {1'b0, step};
        end
    end

    always_comb
    begin
        if (res3_reg > rlht_pkg::THREE_HALF_TURN)
        begin
            wrap_next = res3_reg - rlht_pkg::TWO_TURNS;
        end
        else if (res3_reg > rlht_pkg::HALF_TURN)
        begin
            wrap_next = res3_reg - rlht_pkg::FULL_TURN;
        end
        else if (res3_reg <= -rlht_pkg::THREE_HALF_TURN)
        begin
            wrap_next = res3_reg + rlht_pkg::TWO_TURNS;
        end
        else if (res3_reg <= -rlht_pkg::HALF_TURN)
        begin
            wrap_next = res3_reg + rlht_pkg::FULL_TURN;
        end
        else
        begin
            wrap_next = res3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        want1_reg  <= want_next;
        limit1_reg <= limit_next;
        cur1_reg   <= {{(A - rlht_pkg::YAW_W){in_word.cur[rlht_pkg::YAW_W-1]}}, in_word.cur};
        aimed1_reg <= in_word.aimed;

        mag2_reg   <= mag_abs[rlht_pkg::MAG_W-1:0];
        pos2_reg   <= delta_next > 0;
        want2_reg  <= want1_reg;
        cur2_reg   <= cur1_reg;
        limit2_reg <= limit1_reg;
        aimed2_reg <= aimed1_reg;

        res3_reg   <= res_next;
        aimed3_reg <= aimed2_reg;

        yaw_reg    <= aimed3_reg ? wrap_next[rlht_pkg::YAW_W-1:0] : '0;
        aimed_reg  <= aimed3_reg;
    end

    assign done    = done_reg;
    assign new_yaw = yaw_reg;
    assign aimed   = aimed_reg;

endmodule

// ===== hdl/rlht_checker.sv =====
// Port-level checker for the heading tracker, bound to the top level.
// Depends on rate_limited_heading_tracker_unit_assert.svh.
`timescale 1ns / 1ps
`include "rate_limited_heading_tracker_unit_assert.svh"

module rlht_checker #(
    parameter int LAT = 21
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               target_valid,
    input logic               done,
    input logic signed [15:0] new_yaw,
    input logic               aimed
);

    `RLHT_ASSERT_NOW(a_done_has_word, done, $past(start && !busy, LAT), "result without word")
    `RLHT_ASSERT_NOW(a_word_gives_done, $past(start && !busy, LAT) && $past(rst_n, LAT), done, "word lost")
    `RLHT_ASSERT_NOW(a_idle_yaw_zero, done && !aimed, new_yaw == 16'sd0, "unaimed heading not zero")
    `RLHT_ASSERT_NOW(a_yaw_range, done, (new_yaw <= 16'sd23040) && (new_yaw > -16'sd23040), "heading out of range")
    `RLHT_ASSERT_NOW(a_invalid_unaimed, done && !$past(target_valid, LAT), !aimed, "invalid target aimed")

endmodule

bind rate_limited_heading_tracker_unit rlht_checker #(
    .LAT (CORDIC_STEPS + 5)
) u_rlht_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .target_valid (target_valid),
    .done         (done),
    .new_yaw      (new_yaw),
    .aimed        (aimed)
);

// ===== tb/sv/tb_rate_limited_heading_tracker_unit.sv =====
// Testbench for rate_limited_heading_tracker_unit: directed and random track requests,
// predicted headings checked word by word on the done strobe, yaw_rate swept over APB.
// Depends on rlht_pkg and the block's RTL.
`timescale 1ns / 1ps

localparam longint HALF_Q7 = rlht_pkg::HALF_TURN;
localparam longint FULL_Q7 = rlht_pkg::FULL_TURN;

typedef struct {
    logic signed [19:0] actor_x;
    logic signed [19:0] actor_y;
    logic signed [19:0] target_x;
    logic signed [19:0] target_y;
    logic               target_valid;
    logic signed [15:0] current_yaw;
    logic [15:0]        frame_time;
} track_request_t;

typedef struct {
    logic signed [15:0] new_yaw;
    logic               aimed;
} heading_word_t;

class heading_scoreboard;
    int            steps;
    logic [19:0]   yaw_rate;
    heading_word_t pending_headings[$];
    int            errors;

    function new(int n_steps);
        steps = n_steps;
        yaw_rate = rlht_pkg::YAW_RATE_RESET;
        errors = 0;
    endfunction

    function void complain(string msg);
        errors++;
        $display("%0t %s", $time, msg);
    endfunction

    function longint wrap_turn(longint v);
        longint u;
        u = v + FULL_Q7 * 1000 + HALF_Q7 - 1;
        return (u % FULL_Q7) - (HALF_Q7 - 1);
    endfunction

    function longint bearing_of(longint dx, longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = dx <<< rlht_pkg::PRE_SHIFT;
        y = dy <<< rlht_pkg::PRE_SHIFT;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0 ? HALF_Q7 : -HALF_Q7) * 512;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < steps && i < rlht_pkg::MAX_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                z += longint'(rlht_pkg::ATAN_TABLE[i]);
            end
            else if (y < 0)
            begin
                x -= ys;
                y += xs;
                z -= longint'(rlht_pkg::ATAN_TABLE[i]);
            end
        end
        return wrap_turn((z + 256) >>> rlht_pkg::ROUND_SHIFT);
    endfunction

    function heading_word_t predict_heading(track_request_t r);
        heading_word_t w;
        longint dx;
        longint dy;
        longint cur;
        longint want;
        longint delta;
        longint mag;
        longint limit;
        longint res;
        dx = longint'(r.target_x) - longint'(r.actor_x);
        dy = longint'(r.target_y) - longint'(r.actor_y);
        cur = longint'(r.current_yaw);
        if (!r.target_valid || (dx == 0 && dy == 0))
        begin
            w.new_yaw = '0;
            w.aimed = 1'b0;
            return w;
        end
        want = bearing_of(dx, dy);
        delta = want - cur;
        if (delta > HALF_Q7)
            delta -= FULL_Q7;
        else if (delta < -HALF_Q7)
            delta += FULL_Q7;
        limit = longint'(yaw_rate) * longint'(r.frame_time);
        mag = delta < 0 ? -delta : delta;
        if (limit >= (mag <<< 16))
            res = want;
        else if (delta > 0)
            res = cur + (limit >>> 16);
        else
            res = cur - (limit >>> 16);
        res = wrap_turn(res);
        w.new_yaw = 16'(res);
        w.aimed = 1'b1;
        return w;
    endfunction

    function void note_request(track_request_t r);
        pending_headings.push_back(predict_heading(r));
    endfunction

    function void check_heading(logic signed [15:0] yaw, logic aim);
        heading_word_t e;
        if (pending_headings.size() == 0)
        begin
            complain($sformatf("unexpected word: expected none, actual new_yaw %0d aimed %0d",
                               yaw, aim));
            return;
        end
        e = pending_headings.pop_front();
        if (yaw !== e.new_yaw)
            complain($sformatf("new_yaw: expected %0d actual %0d", e.new_yaw, yaw));
        if (aim !== e.aimed)
            complain($sformatf("aimed: expected %0d actual %0d", e.aimed, aim));
    endfunction

    function int pending();
        return pending_headings.size();
    endfunction
endclass

module tb_rate_limited_heading_tracker_unit;
    localparam int CORDIC_STEPS = 16;
    localparam int LATENCY = CORDIC_STEPS + 5;
    localparam logic [2:0] YAW_RATE_ADDR = 3'(4 * rlht_pkg::YAW_RATE_IDX);

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic signed [19:0] actor_x;
    logic signed [19:0] actor_y;
    logic signed [19:0] target_x;
    logic signed [19:0] target_y;
    logic               target_valid;
    logic signed [15:0] current_yaw;
    logic [15:0]        frame_time;
    logic               done;
    logic signed [15:0] new_yaw;
    logic               aimed;

    heading_scoreboard sb;
    bit                quiet;

    rate_limited_heading_tracker_unit #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .actor_x(actor_x),
        .actor_y(actor_y),
        .target_x(target_x),
        .target_y(target_y),
        .target_valid(target_valid),
        .current_yaw(current_yaw),
        .frame_time(frame_time),
        .done(done),
        .new_yaw(new_yaw),
        .aimed(aimed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("rate_limited_heading_tracker_unit test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_heading(new_yaw, aimed);
    end

    function automatic track_request_t mk_request(int ax, int ay, int tx, int ty, int v,
                                                  int cur, int ft);
        track_request_t r;
        r.actor_x = 20'(ax);
        r.actor_y = 20'(ay);
        r.target_x = 20'(tx);
        r.target_y = 20'(ty);
        r.target_valid = 1'(v);
        r.current_yaw = 16'(cur);
        r.frame_time = 16'(ft);
        return r;
    endfunction

    function automatic track_request_t random_request();
        track_request_t r;
        int unsigned    mode;
        int unsigned    pick;
        int             ox;
        int             oy;
        longint         dx;
        longint         dy;
        longint         want;
        mode = $urandom_range(0, 9);
        r.actor_x = 20'($urandom);
        r.actor_y = 20'($urandom);
        ox = int'($urandom_range(0, 32)) - 16;
        oy = int'($urandom_range(0, 32)) - 16;
        if (mode >= 8)
        begin
            ox = int'($urandom_range(0, 1048575)) - 524288;
            oy = int'($urandom_range(0, 2)) - 1;
        end
        if (mode == 7 || mode == 9)
        begin
            if ($urandom_range(0, 1))
            begin
                pick = ox;
                ox = oy;
                oy = pick;
            end
        end
        if (mode < 4)
        begin
            r.target_x = 20'($urandom);
            r.target_y = 20'($urandom);
        end
        else
        begin
            r.target_x = 20'(int'(r.actor_x) + ox);
            r.target_y = 20'(int'(r.actor_y) + oy);
        end
        r.target_valid = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            r.frame_time = 16'($urandom);
        else if (pick < 8)
            r.frame_time = 16'($urandom_range(0, 1023));
        else if (pick == 8)
            r.frame_time = '0;
        else
            r.frame_time = '1;
        pick = $urandom_range(0, 19);
        dx = longint'(r.target_x) - longint'(r.actor_x);
        dy = longint'(r.target_y) - longint'(r.actor_y);
        if (pick < 14)
            r.current_yaw = 16'(int'($urandom_range(0, 46080)) - 23040);
        else if (pick < 17 || (dx == 0 && dy == 0))
            r.current_yaw = 16'($urandom);
        else
        begin
            want = sb.bearing_of(dx, dy);
            r.current_yaw = 16'(want + longint'($urandom_range(0, 16)) - 8);
        end
        return r;
    endfunction

    task automatic send_request(input track_request_t r);
        start <= 1'b1;
        actor_x <= r.actor_x;
        actor_y <= r.actor_y;
        target_x <= r.target_x;
        target_y <= r.target_y;
        target_valid <= r.target_valid;
        current_yaw <= r.current_yaw;
        frame_time <= r.frame_time;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic run_random(input int count, input bit allow_idle);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 63) == 0)
                quiet = !quiet;
            if (allow_idle && !quiet && $urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
            end
            send_request(random_request());
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [19:0] value);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= YAW_RATE_ADDR;
        pwdata <= {12'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (wr)
            sb.yaw_rate = value;
        else if (got !== {12'd0, sb.yaw_rate})
            sb.complain($sformatf("yaw_rate read: expected %0d actual %0d",
                                  sb.yaw_rate, got));
    endtask

    initial
    begin
        track_request_t directed[$];
        logic [19:0]    rates[6];
        int             counts[6];
        int             guard;

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        start <= 1'b0;
        actor_x <= '0;
        actor_y <= '0;
        target_x <= '0;
        target_y <= '0;
        target_valid <= 1'b0;
        current_yaw <= '0;
        frame_time <= '0;
        quiet = 1'b0;
        sb = new(CORDIC_STEPS);

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, '0);

        directed.push_back(mk_request(100, 100, 100, 100, 1, 500, 1000));
        directed.push_back(mk_request(0, 0, 1000, 1000, 0, 1234, 65535));
        directed.push_back(mk_request(-7, 3, -7, 3, 0, 0, 0));
        directed.push_back(mk_request(0, 0, 1000, 0, 1, 0, 65535));
        directed.push_back(mk_request(0, 0, 0, 1000, 1, 0, 65535));
        directed.push_back(mk_request(0, 0, 0, -1000, 1, 0, 65535));
        directed.push_back(mk_request(0, 0, -1000, 0, 1, 0, 65535));
        directed.push_back(mk_request(0, 0, -1000, 0, 1, -23040, 0));
        directed.push_back(mk_request(0, 0, -1000, 0, 1, 23040, 0));
        directed.push_back(mk_request(-524288, -524288, 524287, 524287, 1, 0, 65535));
        directed.push_back(mk_request(524287, 524287, -524288, -524288, 1, 23040, 65535));
        directed.push_back(mk_request(524287, -524288, -524288, 524287, 1, -23040, 100));
        directed.push_back(mk_request(-524288, 524287, 524287, -524288, 1, 11520, 65535));
        directed.push_back(mk_request(0, 0, 5, 7, 1, 32767, 65535));
        directed.push_back(mk_request(0, 0, 5, -7, 1, -32768, 65535));
        directed.push_back(mk_request(0, 0, 5, 7, 1, 100, 0));
        directed.push_back(mk_request(0, 0, 0, 1000, 1, 11520, 0));
        directed.push_back(mk_request(0, 0, 1, 1, 1, 5760, 0));
        directed.push_back(mk_request(0, 0, -1, -1, 1, 0, 30000));
        directed.push_back(mk_request(0, 0, 1, -1, 1, 0, 12000));
        directed.push_back(mk_request(0, 0, -1, 1, 1, -23039, 65535));
        directed.push_back(mk_request(0, 0, 0, -1, 1, 23040, 32768));
        directed.push_back(mk_request(-1, -1, 0, 0, 1, -1, 65535));
        directed.push_back(mk_request(0, 0, -1, -1, 1, -1, 65535));
        directed.push_back(mk_request(3, 0, 2, 0, 1, 1, 1));
        foreach (directed[k])
            send_request(directed[k]);
        run_random(275, 1'b1);

        rates[0] = '0;
        rates[1] = '1;
        rates[2] = 20'd1;
        rates[3] = 20'($urandom);
        rates[4] = 20'($urandom_range(0, 40000));
        rates[5] = 20'd11520;
        counts = '{150, 150, 100, 150, 150, 150};
        for (int p = 0; p < 6; p++)
        begin
            settle();
            apb_access(1'b1, rates[p]);
            apb_access(1'b0, '0);
            run_random(counts[p], p != 5);
        end

        start <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 8 * LATENCY)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 8)
            @(posedge clk);
        if (sb.pending() != 0)
            sb.complain($sformatf("left over: expected %0d more words, actual none",
                                  sb.pending()));
        if (sb.errors == 0)
            $display("rate_limited_heading_tracker_unit test passed");
        else
            $display("rate_limited_heading_tracker_unit test failed");
        $finish;
    end
endmodule
